@@ src/bsfm_pkg.sv @@
// Package for the binaural speaker FIR mixer.
// Holds the request and result payload types and fixed arithmetic constants.
// No dependencies.
package bsfm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 42;
  localparam int FRAC_W   = 15;
  localparam int ACT_W    = 4;

  localparam logic [ACT_W-1:0]           ACTIVE_RESET = 4'd8;
  localparam logic signed [ACC_W:0]      ROUND_HALF   = 43'sd16384;
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX      = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN      = -16'sh8000;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
  localparam logic EAR_LEFT    = 1'b0;
  localparam logic EAR_RIGHT   = 1'b1;

  typedef struct packed {
    logic                       func;
    logic                       ear;
    logic [2:0]                 speaker;
    logic [6:0]                 tap;
    logic signed [SAMPLE_W-1:0] coef;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       clipped;
  } out_t;

endpackage

@@ src/bsfm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/binaural_speaker_fir_mixer.sv @@
// Sample request: busy through RUN and DRAIN, and on the last speaker of a frame also FINISH,
// where the result registers unless the previous result still waits unread.
// Left and right multiply-accumulate step one tap per cycle; a load request leaves the block idle.
// Reset (rst, synchronous): a clearing pass zeros the whole sample history;
// no request is accepted during it, configuration writes are.
// Depends on bsfm_pkg and bsfm_ram.
module binaural_speaker_fir_mixer
  import bsfm_pkg::*;
#(
  parameter int SPEAKERS = 8,
  parameter int TAPS     = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ACT_W-1:0] cfg_data
);

  localparam int HistDepth = SPEAKERS * TAPS;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int TapW      = $clog2(TAPS);
  localparam int CntW      = ($clog2(SPEAKERS + 1) > ACT_W) ? $clog2(SPEAKERS + 1) : ACT_W;
  localparam int QW        = ACC_W + 1 - FRAC_W;

  typedef enum logic [2:0] {
    CLEAR, IDLE, RUN, DRAIN, FINISH
  } state_t;

  state_t state;

  logic [ACT_W-1:0]           active_speakers;
  logic [TapW-1:0]            pos;
  logic [TapW-1:0]            k;
  logic [TapW-1:0]            rd_pos;
  logic [HistAw-1:0]          base;
  logic [HistAw-1:0]          clr_addr;
  logic                       frame_end;
  logic                       s1_vld;
  logic                       s2_vld;
  logic signed [31:0]         prod_l;
  logic signed [31:0]         prod_r;
  logic signed [ACC_W-1:0]    acc_l;
  logic signed [ACC_W-1:0]    acc_r;

  logic [CntW-1:0]            act_ext;
  logic [CntW-1:0]            act_eff;
  logic [CntW-1:0]            spk_ext;
  logic                       req_take;
  logic                       load_ok;
  logic                       smp_go;
  logic [HistAw-1:0]          in_base;
  logic [HistAw-1:0]          coef_waddr;
  logic                       hist_we;
  logic [HistAw-1:0]          hist_waddr;
  logic [SAMPLE_W-1:0]        hist_wdata;
  logic [SAMPLE_W-1:0]        hist_q;
  logic [SAMPLE_W-1:0]        coefl_q;
  logic [SAMPLE_W-1:0]        coefr_q;
  logic [SAMPLE_W:0]          fin_l;
  logic [SAMPLE_W:0]          fin_r;
  logic [TapW-1:0]            pos_next;
  logic [TapW-1:0]            rd_pos_next;

  function automatic logic [SAMPLE_W:0] finish_acc(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] t;
    logic signed [QW-1:0]  q;
    logic [SAMPLE_W:0]     r;
    t = (ACC_W + 1)'(a) + ROUND_HALF;
    q = t[ACC_W:FRAC_W];
    if (q > QW'(OUT_MAX)) begin
      r = {1'b1, OUT_MAX};
    end else if (q < QW'(OUT_MIN)) begin
      r = {1'b1, OUT_MIN};
    end else begin
      r = {1'b0, q[SAMPLE_W-1:0]};
    end
    return r;
  endfunction

  always_comb begin
    act_ext = CntW'(active_speakers);
    if (act_ext == '0) begin
      act_eff = CntW'(1);
    end else if (act_ext > CntW'(SPEAKERS)) begin
      act_eff = CntW'(SPEAKERS);
    end else begin
      act_eff = act_ext;
    end
    spk_ext    = CntW'(in_data.speaker);
    req_take   = in_valid && in_ready;
    load_ok    = req_take && in_data.func == FUNC_LOAD &&
                 spk_ext < CntW'(SPEAKERS) && int'(in_data.tap) < TAPS;
    smp_go     = req_take && in_data.func == FUNC_SAMPLE && spk_ext < act_eff;
    in_base    = HistAw'(in_data.speaker) * HistAw'(TAPS);
    coef_waddr = in_base + HistAw'(in_data.tap);
    hist_we    = (state == CLEAR) || smp_go;
    hist_waddr = (state == CLEAR) ? clr_addr : in_base + HistAw'(pos);
    hist_wdata = (state == CLEAR) ? '0 : in_data.sample;
    fin_l      = finish_acc(acc_l);
    fin_r      = finish_acc(acc_r);
    pos_next    = (pos == TapW'(TAPS - 1)) ? '0 : pos + 1'b1;
    rd_pos_next = (rd_pos == '0) ? TapW'(TAPS - 1) : rd_pos - 1'b1;
  end

  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  bsfm_ram #(.WIDTH(SAMPLE_W), .DEPTH(HistDepth)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (base + HistAw'(rd_pos)),
    .rdata (hist_q)
  );

  bsfm_ram #(.WIDTH(SAMPLE_W), .DEPTH(HistDepth)) u_coef_l (
    .clk   (clk),
    .we    (load_ok && in_data.ear == EAR_LEFT),
    .waddr (coef_waddr),
    .wdata (in_data.coef),
    .raddr (base + HistAw'(k)),
    .rdata (coefl_q)
  );

  bsfm_ram #(.WIDTH(SAMPLE_W), .DEPTH(HistDepth)) u_coef_r (
    .clk   (clk),
    .we    (load_ok && in_data.ear == EAR_RIGHT),
    .waddr (coef_waddr),
    .wdata (in_data.coef),
    .raddr (base + HistAw'(k)),
    .rdata (coefr_q)
  );

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      prod_l <= $signed(coefl_q) * $signed(hist_q);
      prod_r <= $signed(coefr_q) * $signed(hist_q);
    end
    if (smp_go) begin
      base      <= in_base;
      rd_pos    <= pos;
      frame_end <= (spk_ext == act_eff - 1'b1);
    end else if (state == RUN) begin
      rd_pos <= rd_pos_next;
    end
    if (rst) begin
      state           <= CLEAR;
      clr_addr        <= '0;
      active_speakers <= ACTIVE_RESET;
      pos             <= '0;
      k               <= '0;
      s1_vld          <= 1'b0;
      s2_vld          <= 1'b0;
      acc_l           <= '0;
      acc_r           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_speakers <= cfg_data;
      end
      s1_vld <= (state == RUN);
      s2_vld <= s1_vld;
      if (s2_vld) begin
        acc_l <= acc_l + ACC_W'(prod_l);
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == HistAw'(HistDepth - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (smp_go) begin
            k     <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          k <= k + 1'b1;
          if (k == TapW'(TAPS - 1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!s1_vld && !s2_vld) begin
            state <= frame_end ? FINISH : IDLE;
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            out_data.left_out  <= fin_l[SAMPLE_W-1:0];
            out_data.right_out <= fin_r[SAMPLE_W-1:0];
            out_data.clipped   <= fin_l[SAMPLE_W] | fin_r[SAMPLE_W];
            out_valid          <= 1'b1;
            acc_l              <= '0;
            acc_r              <= '0;
            pos                <= pos_next;
            state              <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_no_req: assert property (@(posedge clk) disable iff (rst)
    (s1_vld || s2_vld) |-> !in_ready)
    else $error("request accepted while multiply-accumulate pipeline busy");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH) |-> (!s1_vld && !s2_vld))
    else $error("frame finished before pipeline drained");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && (!out_valid || out_ready)) |=>
      (out_valid && acc_l == '0 && acc_r == '0 && state == IDLE))
    else $error("frame end did not post result and clear accumulators");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == CLEAR) |-> (!in_ready && !out_valid && !s1_vld))
    else $error("activity during history clearing pass");
`endif

endmodule
